// ===== sv/mlfo_pkg.sv =====
// shared types, constants and the control program for the multi-shape lfo
`default_nettype none

package mlfo_pkg;

  // default sine address width
  localparam int SINE_ADDR_BITS_DEF = 10;

  // configuration port
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 17;
  localparam logic [CFG_INDEX_W-1:0] CFG_WAVE_SHAPE   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RATE_HZ      = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEPTH_GAIN   = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_OFFSET = 8'd3;

  // register reset values
  localparam logic [15:0] RATE_HZ_RST    = 16'd2048;
  localparam logic [16:0] DEPTH_GAIN_RST = 17'd65536;
  localparam logic [16:0] DEPTH_ONE      = 17'd65536;

  // quarter-sine polynomial in q30
  localparam logic [31:0] Q30_ONE = 32'd1073741824;
  localparam logic [31:0] SIN_C1  = 32'd1686629713;
  localparam logic [31:0] SIN_C3  = 32'd693598668;
  localparam logic [31:0] SIN_C5  = 32'd85569306;
  localparam logic [31:0] SIN_C7  = 32'd5026994;
  localparam logic [31:0] SIN_C9  = 32'd172272;

  // sequencer step counter
  localparam int STEP_W = 5;

  typedef enum logic [1:0] {
    SHAPE_SINE   = 2'd0,
    SHAPE_TRI    = 2'd1,
    SHAPE_SAW    = 2'd2,
    SHAPE_SQUARE = 2'd3
  } shape_t;

  // datapath micro-operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_MUL_DT,
    OP_ACC,
    OP_PHASE,
    OP_SINX,
    OP_MUL_XX,
    OP_X2,
    OP_MUL_C9,
    OP_SUBC,
    OP_MUL_X2T,
    OP_MUL_XT,
    OP_HALF,
    OP_WAVE,
    OP_MUL_DEPTH,
    OP_OUT
  } uop_t;

  typedef enum logic [1:0] {
    COEF_C7,
    COEF_C5,
    COEF_C3,
    COEF_C1
  } coef_t;

  // jump conditions
  typedef enum logic [1:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_NOT_SINE,
    JC_END
  } jc_t;

  typedef struct packed {
    uop_t              op;
    coef_t             coef;
    jc_t               jc;
    logic [STEP_W-1:0] target;
  } uword_t;

  // sequencer to datapath
  typedef struct packed {
    logic  load;
    uop_t  op;
    coef_t coef;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic not_sine;
    logic out_busy;
  } status_t;

  localparam logic [STEP_W-1:0] STEP_WAVE  = 5'd16;
  localparam logic [STEP_W-1:0] STEP_DEPTH = 5'd17;
  localparam logic [STEP_W-1:0] STEP_ZERO  = 5'd0;

  // polynomial coefficient by select code
  function automatic logic [31:0] coef_value(coef_t c);
    logic [31:0] v;
    v = SIN_C1;
    case (c)
      COEF_C7: v = SIN_C7;
      COEF_C5: v = SIN_C5;
      COEF_C3: v = SIN_C3;
      default: v = SIN_C1;
    endcase
    return v;
  endfunction

  // control program: one word per step
  function automatic uword_t ucode(logic [STEP_W-1:0] step);
    uword_t w;
    w = '{op: OP_NOP, coef: COEF_C7, jc: JC_END, target: STEP_ZERO};
    case (step)
      5'd0:  w = '{op: OP_MUL_DT,    coef: COEF_C7, jc: JC_NEXT,     target: STEP_ZERO};
      5'd1:  w = '{op: OP_ACC,       coef: COEF_C7, jc: JC_NEXT,     target: STEP_ZERO};
      5'd2:  w = '{op: OP_PHASE,     coef: COEF_C7, jc: JC_NOT_SINE, target: STEP_WAVE};
      5'd3:  w = '{op: OP_SINX,      coef: COEF_C7, jc: JC_NEXT,     target: STEP_ZERO};
      5'd4:  w = '{op: OP_MUL_XX,    coef: COEF_C7, jc: JC_NEXT,     target: STEP_ZERO};
      5'd5:  w = '{op: OP_X2,        coef: COEF_C7, jc: JC_NEXT,     target: STEP_ZERO};
      5'd6:  w = '{op: OP_MUL_C9,    coef: COEF_C7, jc: JC_NEXT,     target: STEP_ZERO};
      5'd7:  w = '{op: OP_SUBC,      coef: COEF_C7, jc: JC_NEXT,     target: STEP_ZERO};
      5'd8:  w = '{op: OP_MUL_X2T,   coef: COEF_C7, jc: JC_NEXT,     target: STEP_ZERO};
      5'd9:  w = '{op: OP_SUBC,      coef: COEF_C5, jc: JC_NEXT,     target: STEP_ZERO};
      5'd10: w = '{op: OP_MUL_X2T,   coef: COEF_C7, jc: JC_NEXT,     target: STEP_ZERO};
      5'd11: w = '{op: OP_SUBC,      coef: COEF_C3, jc: JC_NEXT,     target: STEP_ZERO};
      5'd12: w = '{op: OP_MUL_X2T,   coef: COEF_C7, jc: JC_NEXT,     target: STEP_ZERO};
      5'd13: w = '{op: OP_SUBC,      coef: COEF_C1, jc: JC_NEXT,     target: STEP_ZERO};
      5'd14: w = '{op: OP_MUL_XT,    coef: COEF_C7, jc: JC_NEXT,     target: STEP_ZERO};
      5'd15: w = '{op: OP_HALF,      coef: COEF_C7, jc: JC_ALWAYS,   target: STEP_DEPTH};
      5'd16: w = '{op: OP_WAVE,      coef: COEF_C7, jc: JC_NEXT,     target: STEP_ZERO};
      5'd17: w = '{op: OP_MUL_DEPTH, coef: COEF_C7, jc: JC_NEXT,     target: STEP_ZERO};
      5'd18: w = '{op: OP_OUT,       coef: COEF_C7, jc: JC_END,      target: STEP_ZERO};
      default: w = '{op: OP_NOP, coef: COEF_C7, jc: JC_END, target: STEP_ZERO};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== sv/mlfo_in_if.sv =====
// input channel: elapsed time per tick
`default_nettype none

interface mlfo_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] elapsed_time;

  modport source (output valid, output elapsed_time, input ready);
  modport sink   (input valid, input elapsed_time, output ready);
endinterface

`default_nettype wire

// ===== sv/mlfo_out_if.sv =====
// output channel: modulation value
`default_nettype none

interface mlfo_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] mod_value;

  modport source (output valid, output mod_value, input ready);
  modport sink   (input valid, input mod_value, output ready);
endinterface

`default_nettype wire

// ===== sv/mlfo_useq.sv =====
// microcode sequencer: step counter, program table and jump logic
`default_nettype none

module mlfo_useq
  import mlfo_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output ctrl_t        ctrl
);

  logic              busy;
  logic [STEP_W-1:0] step;
  uword_t            word;
  logic              stall;
  logic              run;

  // fetch the control word of the current step
  assign word     = ucode(step);
  assign stall    = (word.op == OP_OUT) && status.out_busy;
  assign run      = busy && !stall;
  assign in_ready = !busy;

  // drive the datapath
  always_comb begin
    ctrl.load = in_valid && !busy;
    ctrl.op   = run ? word.op : OP_NOP;
    ctrl.coef = word.coef;
  end

  // step counter and jumps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= STEP_ZERO;
    end else if (!busy) begin
      if (in_valid) begin
        busy <= 1'b1;
        step <= STEP_ZERO;
      end
    end else if (run) begin
      unique case (word.jc)
        JC_NEXT:     step <= step + 1'b1;
        JC_ALWAYS:   step <= word.target;
        JC_NOT_SINE: step <= status.not_sine ? word.target : step + 1'b1;
        JC_END:      busy <= 1'b0;
        default:     busy <= 1'b0;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/mlfo_dpath.sv =====
// datapath: config registers, phase accumulator, shared multiplier, wave and output
`default_nettype none

module mlfo_dpath
  import mlfo_pkg::*;
#(
  parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire ctrl_t                  ctrl,
  output status_t                     status,
  input  wire logic [15:0]            elapsed_time,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [16:0]                 mod_value
);

  localparam int QBITS = SINE_ADDR_BITS - 2;
  localparam int XSH   = 30 - QBITS;

  shape_t      wave_shape;
  logic [15:0] rate_hz;
  logic [16:0] depth_gain;
  logic [15:0] phase_offset;

  logic [15:0] dt;
  logic [31:0] phase_acc;
  logic [31:0] p;
  logic [30:0] x;
  logic [30:0] x2;
  logic [31:0] t;
  logic [1:0]  quad;
  logic [16:0] wave;
  logic [63:0] prod;

  logic [31:0]               mul_a;
  logic [31:0]               mul_b;
  logic [31:0]               prod_q30;
  logic [31:0]               t_clamp;
  logic [15:0]               half;
  logic [16:0]               depth_sat;
  logic [SINE_ADDR_BITS-1:0] addr;
  logic [QBITS-1:0]          quarter_idx;
  logic [QBITS:0]            pos;
  logic [15:0]               p16;
  logic [16:0]               wave_other;

  assign status.not_sine = (wave_shape != SHAPE_SINE);
  assign status.out_busy = out_valid && !out_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_shape   <= SHAPE_SINE;
      rate_hz      <= RATE_HZ_RST;
      depth_gain   <= DEPTH_GAIN_RST;
      phase_offset <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WAVE_SHAPE:   wave_shape   <= shape_t'(cfg_data[1:0]);
        CFG_RATE_HZ:      rate_hz      <= cfg_data[15:0];
        CFG_DEPTH_GAIN:   depth_gain   <= cfg_data;
        CFG_PHASE_OFFSET: phase_offset <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.op)
      OP_MUL_DT: begin
        mul_a = {16'd0, dt};
        mul_b = {16'd0, rate_hz};
      end
      OP_MUL_XX: begin
        mul_a = {1'b0, x};
        mul_b = {1'b0, x};
      end
      OP_MUL_C9: begin
        mul_a = {1'b0, x2};
        mul_b = SIN_C9;
      end
      OP_MUL_X2T: begin
        mul_a = {1'b0, x2};
        mul_b = t;
      end
      OP_MUL_XT: begin
        mul_a = {1'b0, x};
        mul_b = t;
      end
      OP_MUL_DEPTH: begin
        mul_a = {15'd0, wave};
        mul_b = {15'd0, depth_sat};
      end
      default: ;
    endcase
  end

  // sine address split and quarter mirror
  assign addr        = p[31 -: SINE_ADDR_BITS];
  assign quarter_idx = addr[QBITS-1:0];
  assign pos         = addr[QBITS] ? ((QBITS+1)'(1) << QBITS) - {1'b0, quarter_idx}
                                   : {1'b0, quarter_idx};

  // q30 view of the product, clamp to one for the last polynomial step
  assign prod_q30 = prod[61:30];
  assign t_clamp  = (prod_q30 > Q30_ONE) ? Q30_ONE : prod_q30;
  assign half     = t_clamp[30:15];

  assign depth_sat = (depth_gain > DEPTH_ONE) ? DEPTH_ONE : depth_gain;

  // triangle, saw and square
  assign p16 = p[31:16];
  always_comb begin
    wave_other = '0;
    unique case (wave_shape)
      SHAPE_TRI:    wave_other = p16[15] ? 17'(18'd131072 - {1'b0, p16, 1'b0})
                                         : {p16, 1'b0};
      SHAPE_SAW:    wave_other = {1'b0, p16};
      SHAPE_SQUARE: wave_other = p16[15] ? 17'd0 : DEPTH_ONE;
      SHAPE_SINE:   wave_other = '0;
      default:      wave_other = '0;
    endcase
  end

  // phase accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
    end else if (ctrl.op == OP_ACC) begin
      phase_acc <= phase_acc + {prod[26:0], 5'd0};
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      dt <= elapsed_time;
    end
    case (ctrl.op) inside
      OP_MUL_DT, OP_MUL_XX, OP_MUL_C9, OP_MUL_X2T, OP_MUL_XT, OP_MUL_DEPTH: begin
        prod <= mul_a * mul_b;
      end
      OP_PHASE: p    <= phase_acc + {phase_offset, 16'd0};
      OP_SINX: begin
        x    <= {pos, XSH'(0)};
        quad <= addr[SINE_ADDR_BITS-1 -: 2];
      end
      OP_X2:   x2   <= prod[60:30];
      OP_SUBC: t    <= coef_value(ctrl.coef) - prod_q30;
      OP_HALF: wave <= quad[1] ? 17'd32768 - {1'b0, half} : 17'd32768 + {1'b0, half};
      OP_WAVE: wave <= wave_other;
      OP_OUT:  mod_value <= prod[32:16];
      default: ;
    endcase
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== sv/multi_shape_lfo_top.sv =====
// top level of the multi-shape lfo
//
//  channel  dir  handshake        payload
//  in_ch    in   valid / ready    elapsed_time [15:0], seconds q0.16
//  out_ch   out  valid / ready    mod_value [16:0], q1.16
//  cfg      in   cfg_we           cfg_index [7:0], cfg_data [16:0]
//
// a sine tick runs 18 program steps and any other shape 6, on one shared 32x32
// multiplier. a finished result sits in the output register while the next
// tick runs. the last step waits if the previous result has not been taken
// yet. synchronous reset clears the phase and loads the register defaults.
`default_nettype none

module multi_shape_lfo_top
  import mlfo_pkg::*;
#(
  parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  mlfo_in_if.sink                     in_ch,
  mlfo_out_if.source                  out_ch,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  ctrl_t   ctrl;
  status_t status;

  // sequencer
  mlfo_useq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .ctrl     (ctrl)
  );

  // datapath
  mlfo_dpath #(
    .SINE_ADDR_BITS (SINE_ADDR_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .status       (status),
    .elapsed_time (in_ch.elapsed_time),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .mod_value    (out_ch.mod_value)
  );

`ifndef NO_ASSERTIONS
  // a tick transfer starts the program, so no second tick next cycle
  a_busy_after_load: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while program running");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_OUT) |-> !(out_ch.valid && !out_ch.ready))
    else $error("result overwritten before transfer");

  // scaled output stays within one
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.mod_value <= 17'd65536))
    else $error("mod_value above one");
`endif

endmodule

`default_nettype wire
